// File: hw/rtl/rtc_pkg.sv
package rtc_pkg;

   localparam int CORDIC_STAGES_DEFAULT   = 16;
   localparam int COMPONENT_WIDTH_DEFAULT = 16;
   localparam logic [15:0] EPSILON_SQUARED_RESET = 16'd7;

   // Arctangent of 2^-i in units of 2^32 per turn.
   localparam logic [31:0] ATAN_TURNS [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [1:0] {
      PATH_ROTATED  = 2'd0,
      PATH_FALLBACK = 2'd1,
      PATH_DESIRED  = 2'd2,
      PATH_ZERO     = 2'd3
   } path_type;

   typedef struct packed {
      logic signed [15:0] heading_x;
      logic signed [15:0] heading_y;
      logic signed [15:0] desired_x;
      logic signed [15:0] desired_y;
      logic        [15:0] max_turn;
      logic signed [15:0] fallback_x;
      logic signed [15:0] fallback_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic        [1:0]  path_taken;
      logic               turn_clamped;
   } rsp_type;

   // Control that rides along with each transaction through the cells.
   typedef struct packed {
      logic        valid;
      path_type    path;
      logic        clamped;
      logic        flip;
      logic [15:0] max_turn;
   } side_type;

endpackage

// File: hw/rtl/rtc_vec_cell.sv
module rtc_vec_cell #(
   parameter int VW    = 19,
   parameter int STAGE = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rtc_pkg::side_type      side_in,
   input  logic signed [VW-1:0]   ax_in,
   input  logic signed [VW-1:0]   ay_in,
   input  logic        [31:0]     az_in,
   input  logic signed [VW-1:0]   bx_in,
   input  logic signed [VW-1:0]   by_in,
   input  logic        [31:0]     bz_in,
   output rtc_pkg::side_type      side_ff,
   output logic signed [VW-1:0]   ax_ff,
   output logic signed [VW-1:0]   ay_ff,
   output logic        [31:0]     az_ff,
   output logic signed [VW-1:0]   bx_ff,
   output logic signed [VW-1:0]   by_ff,
   output logic        [31:0]     bz_ff
);
   import rtc_pkg::*;

   localparam logic [31:0] ATAN = ATAN_TURNS[STAGE];

   // One vectoring micro-rotation drives y toward zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else begin
         side_ff <= side_in;
      end
      if (ay_in >= 0) begin
         ax_ff <= ax_in + (ay_in >>> STAGE);
         ay_ff <= ay_in - (ax_in >>> STAGE);
         az_ff <= az_in + ATAN;
      end else begin
         ax_ff <= ax_in - (ay_in >>> STAGE);
         ay_ff <= ay_in + (ax_in >>> STAGE);
         az_ff <= az_in - ATAN;
      end
      if (by_in >= 0) begin
         bx_ff <= bx_in + (by_in >>> STAGE);
         by_ff <= by_in - (bx_in >>> STAGE);
         bz_ff <= bz_in + ATAN;
      end else begin
         bx_ff <= bx_in - (by_in >>> STAGE);
         by_ff <= by_in + (bx_in >>> STAGE);
         bz_ff <= bz_in - ATAN;
      end
   end

endmodule

// File: hw/rtl/rtc_rot_cell.sv
module rtc_rot_cell #(
   parameter int RW    = 17,
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rtc_pkg::side_type    side_in,
   input  logic signed [RW-1:0] x_in,
   input  logic signed [RW-1:0] y_in,
   input  logic signed [32:0]   z_in,
   output rtc_pkg::side_type    side_ff,
   output logic signed [RW-1:0] x_ff,
   output logic signed [RW-1:0] y_ff,
   output logic signed [32:0]   z_ff
);
   import rtc_pkg::*;

   localparam logic signed [32:0] ATAN = {1'b0, ATAN_TURNS[STAGE]};

   // One rotation-mode micro-rotation drives the residual angle toward zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else begin
         side_ff <= side_in;
      end
      if (z_in >= 0) begin
         x_ff <= x_in - (y_in >>> STAGE);
         y_ff <= y_in + (x_in >>> STAGE);
         z_ff <= z_in - ATAN;
      end else begin
         x_ff <= x_in + (y_in >>> STAGE);
         y_ff <= y_in - (x_in >>> STAGE);
         z_ff <= z_in + ATAN;
      end
   end

endmodule

// File: hw/rtl/rotate_toward_clamped_unit.sv
// Rate-limited turning of a 2-D heading toward a desired direction.
//
// Input channel: a transaction is taken at a rising clock edge where start
// is high and busy is low. Busy is always low, so one transaction can enter
// in every cycle. req_data carries heading, desired direction, largest turn
// and fallback direction.
// Result channel: each transaction gives exactly one result on rsp_data,
// marked by rsp_valid for one cycle. rsp_valid is the output register and
// rises after the transaction has passed the input register, the vectoring
// register, the vectoring row, the turn register and the rotation row, and
// the result is taken at the next edge. Results leave in order.
// Throughput is one transaction per cycle, set by the two unrolled rows of
// CORDIC cells (vectoring, then rotation) that shift every cycle.
// The receiver cannot stall, so nothing ever waits inside the block.
// Configuration: csr_we writes csr_wdata into the epsilon_squared threshold
// at the next edge; write it only while no transaction is in flight.
// Reset is synchronous: it empties the pipeline and sets the threshold to 7.
module rotate_toward_clamped_unit #(
   parameter int CORDIC_STAGES   = rtc_pkg::CORDIC_STAGES_DEFAULT,
   parameter int COMPONENT_WIDTH = rtc_pkg::COMPONENT_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rtc_pkg::req_type req_data,
   output logic             rsp_valid,
   output rtc_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [15:0]      csr_wdata
);
   import rtc_pkg::*;

   localparam int N   = CORDIC_STAGES;
   localparam int W   = COMPONENT_WIDTH;
   // Vectoring width: scaled input plus CORDIC gain and sqrt(2) growth.
   localparam int VW  = ((W > 16) ? W : 16) + 3;
   localparam int SHL = (W >= 16) ? W - 16 : 0;
   localparam int SHR = (W < 16) ? 16 - W : 0;
   // Rotation datapath has W-2 fraction bits.
   localparam int RW  = W + 1;
   localparam int GSH = 32 - W;
   localparam longint GHALF = (GSH > 0) ? (longint'(1) << (GSH - 1)) : 0;
   localparam longint GAIN  = (longint'(32'h26DD3B6A) + GHALF) >>> GSH;
   // Rounding of the rotation result down to Q1.14.
   localparam int QW  = RW + 6;
   localparam int QS  = (W >= 16) ? W - 16 : 0;
   localparam int QL  = (W < 16) ? 16 - W : 0;
   localparam longint QHALF = (QS > 0) ? (longint'(1) << (QS - 1)) : 0;

   assign busy = 1'b0;

   // Threshold register.
   logic [15:0] eps_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPSILON_SQUARED_RESET;
      end else if (csr_we) begin
         eps_ff <= csr_wdata;
      end
   end

   // Input register.
   logic    s1_valid_ff;
   req_type s1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
      s1_ff <= req_data;
   end

   // Zero-length tests and selection of the vector that gets measured.
   logic signed [31:0] hxx, hyy, dxx, dyy, fxx, fyy;
   logic [32:0] hmag, dmag, fmag;
   logic h_zero, d_zero, f_zero;
   logic signed [15:0] ax_raw, ay_raw;
   logic signed [VW-1:0] ax_sc, ay_sc, bx_sc, by_sc;
   side_type side0_in;
   logic signed [VW-1:0] ax0_in, ay0_in, bx0_in, by0_in;
   logic [31:0] az0_in, bz0_in;

   always_comb begin
      hxx = s1_ff.heading_x * s1_ff.heading_x;
      hyy = s1_ff.heading_y * s1_ff.heading_y;
      dxx = s1_ff.desired_x * s1_ff.desired_x;
      dyy = s1_ff.desired_y * s1_ff.desired_y;
      fxx = s1_ff.fallback_x * s1_ff.fallback_x;
      fyy = s1_ff.fallback_y * s1_ff.fallback_y;
      hmag = {1'b0, hxx} + {1'b0, hyy};
      dmag = {1'b0, dxx} + {1'b0, dyy};
      fmag = {1'b0, fxx} + {1'b0, fyy};
      h_zero = hmag <= {17'd0, eps_ff};
      d_zero = dmag <= {17'd0, eps_ff};
      f_zero = fmag <= {17'd0, eps_ff};

      ax_raw = h_zero ? s1_ff.fallback_x : s1_ff.heading_x;
      ay_raw = h_zero ? s1_ff.fallback_y : s1_ff.heading_y;
      ax_sc = (VW'(ax_raw) <<< SHL) >>> SHR;
      ay_sc = (VW'(ay_raw) <<< SHL) >>> SHR;
      bx_sc = (VW'(s1_ff.desired_x) <<< SHL) >>> SHR;
      by_sc = (VW'(s1_ff.desired_y) <<< SHL) >>> SHR;

      // A vector in the left half-plane is turned by half a turn first.
      if (ax_sc < 0) begin
         ax0_in = -ax_sc;
         ay0_in = -ay_sc;
         az0_in = 32'h80000000;
      end else begin
         ax0_in = ax_sc;
         ay0_in = ay_sc;
         az0_in = 32'd0;
      end
      if (bx_sc < 0) begin
         bx0_in = -bx_sc;
         by0_in = -by_sc;
         bz0_in = 32'h80000000;
      end else begin
         bx0_in = bx_sc;
         by0_in = by_sc;
         bz0_in = 32'd0;
      end

      side0_in.valid    = s1_valid_ff;
      side0_in.clamped  = 1'b0;
      side0_in.flip     = 1'b0;
      side0_in.max_turn = s1_ff.max_turn;
      if (h_zero) begin
         side0_in.path = f_zero ? PATH_ZERO : PATH_FALLBACK;
      end else begin
         side0_in.path = d_zero ? PATH_DESIRED : PATH_ROTATED;
      end
   end

   logic signed [VW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [31:0] az_ff, bz_ff;
   side_type vside_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vside_ff.valid <= 1'b0;
      end else begin
         vside_ff <= side0_in;
      end
      ax_ff <= ax0_in;
      ay_ff <= ay0_in;
      az_ff <= az0_in;
      bx_ff <= bx0_in;
      by_ff <= by0_in;
      bz_ff <= bz0_in;
   end

   // Vectoring row: both angles are measured side by side.
   side_type             vs [N+1];
   logic signed [VW-1:0] vax [N+1], vay [N+1], vbx [N+1], vby [N+1];
   logic [31:0]          vaz [N+1], vbz [N+1];

   assign vs[0]  = vside_ff;
   assign vax[0] = ax_ff;
   assign vay[0] = ay_ff;
   assign vaz[0] = az_ff;
   assign vbx[0] = bx_ff;
   assign vby[0] = by_ff;
   assign vbz[0] = bz_ff;

   for (genvar i = 0; i < N; i++) begin : g_vec
      rtc_vec_cell #(.VW(VW), .STAGE(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .side_in (vs[i]),
         .ax_in   (vax[i]),
         .ay_in   (vay[i]),
         .az_in   (vaz[i]),
         .bx_in   (vbx[i]),
         .by_in   (vby[i]),
         .bz_in   (vbz[i]),
         .side_ff (vs[i+1]),
         .ax_ff   (vax[i+1]),
         .ay_ff   (vay[i+1]),
         .az_ff   (vaz[i+1]),
         .bx_ff   (vbx[i+1]),
         .by_ff   (vby[i+1]),
         .bz_ff   (vbz[i+1])
      );
   end

   // Turn selection: round both angles to 16 bits per turn, take the
   // shortest signed difference, clamp it, and fold the target angle into
   // the right half-plane for the rotation row.
   logic [31:0] ah_sum, ad_sum;
   logic [15:0] ah, ad, dif, theta;
   logic signed [16:0] dsg, mlim, step;
   logic signed [32:0] zt, zf;
   side_type side_r_in;

   always_comb begin
      ah_sum = vaz[N] + 32'h8000;
      ad_sum = vbz[N] + 32'h8000;
      ah  = ah_sum[31:16];
      ad  = ad_sum[31:16];
      dif = ad - ah;
      // An exact half turn counts as positive.
      dsg = (dif == 16'h8000) ? 17'sd32768 : {dif[15], dif};
      mlim = {1'b0, vs[N].max_turn};
      side_r_in = vs[N];
      side_r_in.clamped = 1'b0;
      if (dsg > mlim) begin
         step = mlim;
         side_r_in.clamped = 1'b1;
      end else if (dsg < -mlim) begin
         step = -mlim;
         side_r_in.clamped = 1'b1;
      end else begin
         step = dsg;
      end
      if (vs[N].path == PATH_ROTATED) begin
         theta = ah + step[15:0];
      end else begin
         theta = ah;
         side_r_in.clamped = 1'b0;
      end

      zt = 33'(signed'({theta, 16'd0}));
      side_r_in.flip = 1'b0;
      zf = zt;
      if (zt > 33'sh040000000) begin
         zf = zt - 33'sh080000000;
         side_r_in.flip = 1'b1;
      end else if (zt < -33'sh040000000) begin
         zf = zt + 33'sh080000000;
         side_r_in.flip = 1'b1;
      end
   end

   side_type rside_ff;
   logic signed [32:0] rz_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rside_ff.valid <= 1'b0;
      end else begin
         rside_ff <= side_r_in;
      end
      rz_ff <= zf;
   end

   // Rotation row: unit vector at the chosen angle, gain compensated up front.
   side_type             rs [N+1];
   logic signed [RW-1:0] rx [N+1], ry [N+1];
   logic signed [32:0]   rz [N+1];

   assign rs[0] = rside_ff;
   assign rx[0] = RW'(GAIN);
   assign ry[0] = '0;
   assign rz[0] = rz_ff;

   for (genvar i = 0; i < N; i++) begin : g_rot
      rtc_rot_cell #(.RW(RW), .STAGE(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .side_in (rs[i]),
         .x_in    (rx[i]),
         .y_in    (ry[i]),
         .z_in    (rz[i]),
         .side_ff (rs[i+1]),
         .x_ff    (rx[i+1]),
         .y_ff    (ry[i+1]),
         .z_ff    (rz[i+1])
      );
   end

   // Output stage: round half up to Q1.14, saturate, undo the fold, zero the zero path.
   logic signed [QW-1:0] qx, qy;
   logic signed [15:0] ox, oy;
   rsp_type rsp_in;

   always_comb begin
      qx = ((QW'(rx[N]) + QW'(QHALF)) >>> QS) <<< QL;
      qy = ((QW'(ry[N]) + QW'(QHALF)) >>> QS) <<< QL;
      if (qx > QW'(16384)) begin
         ox = 16'sd16384;
      end else if (qx < -QW'(16384)) begin
         ox = -16'sd16384;
      end else begin
         ox = qx[15:0];
      end
      if (qy > QW'(16384)) begin
         oy = 16'sd16384;
      end else if (qy < -QW'(16384)) begin
         oy = -16'sd16384;
      end else begin
         oy = qy[15:0];
      end
      if (rs[N].flip) begin
         ox = -ox;
         oy = -oy;
      end
      if (rs[N].path == PATH_ZERO) begin
         ox = '0;
         oy = '0;
      end
      rsp_in.dir_x        = ox;
      rsp_in.dir_y        = oy;
      rsp_in.path_taken   = rs[N].path;
      rsp_in.turn_clamped = rs[N].clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= rs[N].valid;
      end
      rsp_data <= rsp_in;
   end

endmodule

// File: hw/rtl/rtc_checker.sv
module rtc_checker #(
   parameter int CORDIC_STAGES = rtc_pkg::CORDIC_STAGES_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input rtc_pkg::rsp_type rsp_data,
   input logic             rsp_valid
);
   import rtc_pkg::*;

   localparam int LAT = 2 * CORDIC_STAGES + 4;

   // Every accepted transaction produces a result on rsp_valid.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result missing after accepted transaction");

   // No result appears without a matching accepted transaction.
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start, LAT) && !$past(busy, LAT)))
      else $error("result without matching transaction");

   // The all-degenerate path returns the zero vector.
   a_zero_path : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.path_taken == PATH_ZERO) |->
      (rsp_data.dir_x == 16'sd0 && rsp_data.dir_y == 16'sd0))
      else $error("zero path with nonzero direction");

   // Clamping can only be reported on the rotated path.
   a_clamp_path : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.turn_clamped) |-> (rsp_data.path_taken == PATH_ROTATED))
      else $error("clamp flag outside rotated path");

endmodule

bind rotate_toward_clamped_unit rtc_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_rtc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid)
);
